>>> rtl/core/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode, jsu_out_buf and json_string_unescape_utf8; no dependencies.
`default_nettype none

package jsu_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_CLOSED   = 2'd1;
    localparam logic [1:0] KIND_NO_OPEN  = 2'd2;
    localparam logic [1:0] KIND_UNTERM   = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       text_end;
    } text_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } utf8_t;

    // Up to four results produced by one input beat, entry 0 goes out first.
    typedef struct packed {
        logic [2:0]                      cnt;
        logic [MaxResults-1:0][7:0]      data;
        logic [MaxResults-1:0][1:0]      kinds;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/jsu_decode.sv
// Escape decoder state machine and UTF-8 encoder for one input beat.
// Depends on jsu_pkg for the beat and result types.
`default_nettype none

module jsu_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jsu_pkg::text_t item,
    input  wire logic           fire,
    output jsu_pkg::res_t       res
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_STR,
        M_ESC,
        M_HEX,
        M_HIGH,
        M_HIGH_BS,
        M_LOW
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [20:0] PAIR_BASE   = 21'h002400;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            CH_LOW_B: b = 8'h08;
            CH_LOW_F: b = 8'h0C;
            CH_LOW_N: b = 8'h0A;
            CH_LOW_R: b = 8'h0D;
            CH_LOW_T: b = 8'h09;
            default:  b = c;
        endcase
        return b;
    endfunction

    function automatic jsu_pkg::res_t utf8_enc(input logic [20:0] cp);
        jsu_pkg::res_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.cnt     = 3'd1;
            r.data[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.cnt     = 3'd2;
            r.data[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.data[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.cnt     = 3'd3;
            r.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
            r.data[1] = 8'h80 | {2'b00, cp[11:6]};
            r.data[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            r.cnt     = 3'd4;
            r.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
            r.data[1] = 8'h80 | {2'b00, cp[17:12]};
            r.data[2] = 8'h80 | {2'b00, cp[11:6]};
            r.data[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] code_reg, code_next;
    logic [15:0] high_reg, high_next;

    logic [7:0]    c;
    logic [15:0]   dig;
    logic          hex_done;
    logic          dig_is_high;
    logic [20:0]   pair_cp;
    jsu_pkg::res_t high_enc;
    logic          sb_emit;
    logic [7:0]    sb_byte;
    logic [1:0]    sb_kind;
    mode_t         sb_mode;
    logic          eb_is_u;
    logic [7:0]    eb_byte;

    always_comb
    begin
        c           = item.char_byte;
        dig         = {code_reg[11:0], hex_val(c)};
        hex_done    = (hex_cnt_reg == 2'd3);
        dig_is_high = (dig >= SURR_HI_MIN) && (dig <= SURR_HI_MAX);
        pair_cp     = PAIR_BASE + {1'b0, high_reg[9:0], 10'b0} + {5'b00000, dig};
        high_enc    = utf8_enc({5'b00000, high_reg});

        sb_emit = 1'b1;
        sb_byte = c;
        sb_kind = jsu_pkg::KIND_DATA;
        sb_mode = M_STR;
        if (c == CH_QUOTE) begin
            sb_byte = 8'h00;
            sb_kind = jsu_pkg::KIND_CLOSED;
            sb_mode = M_IDLE;
        end else if (c == CH_BSLASH) begin
            sb_emit = 1'b0;
            sb_mode = M_ESC;
        end

        eb_is_u = (c == CH_LOW_U);
        eb_byte = esc_map(c);

        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        code_next    = code_reg;
        high_next    = high_reg;
        res          = '0;

        if (item.text_end) begin
            mode_next    = M_IDLE;
            hex_cnt_next = 2'd0;
            code_next    = 16'd0;
            high_next    = 16'd0;
            case (mode_reg)
                M_STR, M_ESC, M_HEX, M_LOW:
                begin
                    res.cnt      = 3'd1;
                    res.kinds[0] = jsu_pkg::KIND_UNTERM;
                end
                M_HIGH, M_HIGH_BS:
                begin
                    res          = high_enc;
                    res.cnt      = 3'd4;
                    res.kinds[3] = jsu_pkg::KIND_UNTERM;
                end
                default:
                begin
                    res.cnt      = 3'd1;
                    res.kinds[0] = jsu_pkg::KIND_NO_OPEN;
                end
            endcase
        end else begin
            case (mode_reg)
                M_STR:
                begin
                    mode_next = sb_mode;
                    if (sb_emit) begin
                        res.cnt      = 3'd1;
                        res.data[0]  = sb_byte;
                        res.kinds[0] = sb_kind;
                    end
                end
                M_ESC:
                begin
                    if (eb_is_u) begin
                        mode_next    = M_HEX;
                        hex_cnt_next = 2'd0;
                        code_next    = 16'd0;
                    end else begin
                        mode_next   = M_STR;
                        res.cnt     = 3'd1;
                        res.data[0] = eb_byte;
                    end
                end
                M_HEX:
                begin
                    code_next    = dig;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    if (hex_done) begin
                        if (dig_is_high) begin
                            high_next = dig;
                            mode_next = M_HIGH;
                        end else begin
                            res       = utf8_enc({5'b00000, dig});
                            mode_next = M_STR;
                        end
                    end
                end
                M_HIGH:
                begin
                    if (c == CH_BSLASH) begin
                        mode_next = M_HIGH_BS;
                    end else begin
                        res       = high_enc;
                        mode_next = sb_mode;
                        if (sb_emit) begin
                            res.cnt      = 3'd4;
                            res.data[3]  = sb_byte;
                            res.kinds[3] = sb_kind;
                        end
                    end
                end
                M_HIGH_BS:
                begin
                    if (eb_is_u) begin
                        mode_next    = M_LOW;
                        hex_cnt_next = 2'd0;
                        code_next    = 16'd0;
                    end else begin
                        res         = high_enc;
                        res.cnt     = 3'd4;
                        res.data[3] = eb_byte;
                        mode_next   = M_STR;
                    end
                end
                M_LOW:
                begin
                    code_next    = dig;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    if (hex_done) begin
                        res       = utf8_enc(pair_cp);
                        mode_next = M_STR;
                    end
                end
                default:
                begin
                    if (c == CH_QUOTE) begin
                        mode_next = M_STR;
                    end else begin
                        mode_next    = M_IDLE;
                        res.cnt      = 3'd1;
                        res.kinds[0] = jsu_pkg::KIND_NO_OPEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= M_IDLE;
            hex_cnt_reg <= 2'd0;
            code_reg    <= 16'd0;
            high_reg    <= 16'd0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            code_reg    <= code_next;
            high_reg    <= high_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_out_buf.sv
// Result register for one beat's results; sends them one per cycle unless stalled.
// Depends on jsu_pkg for the result and output beat types.
`default_nettype none

module jsu_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire jsu_pkg::res_t res,
    output logic               free,
    output logic               valid,
    input  wire logic          stall,
    output jsu_pkg::utf8_t     data
);

    jsu_pkg::res_t ent_reg;
    logic [2:0]    rem_reg;
    logic [1:0]    pos_reg;
    logic          pop;

    assign valid         = (rem_reg != 3'd0);
    assign pop           = valid && !stall;
    assign free          = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && pop);
    assign data.out_byte = ent_reg.data[pos_reg];
    assign data.kind     = ent_reg.kinds[pos_reg];
    assign data.last     = (rem_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 3'd0;
            pos_reg <= 2'd0;
        end else if (load) begin
            rem_reg <= res.cnt;
            pos_reg <= 2'd0;
        end else if (pop) begin
            rem_reg <= rem_reg - 3'd1;
            pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            ent_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("Results loaded over undelivered results.");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && data.last && !load) |=> !valid)
        else $error("Output still valid after its final beat was taken.");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd4)
        else $error("Remaining result count out of range.");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid)
        else $error("Loaded results did not appear at the output.");
`endif

endmodule

`default_nettype wire

>>> rtl/core/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_decode and jsu_out_buf.
//
//   Channel  Direction  Beat      Handshake
//   text     in         text_t    text_valid / text_stall
//   utf8     out        utf8_t    utf8_valid / utf8_stall
//
// A text beat is registered, decoded combinationally and its results land in the result register.
// The first result is presented from the result register once the beat has left the input register.
// A beat with zero or one result leaves room for the next beat in the following cycle unless the output stalls.
// A beat with more than one result holds the next beat in the input register while they drain.
// Reset clears the decoder state and both registers' valid flags; no clearing pass is needed.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           text_valid,
    output logic                text_stall,
    input  wire jsu_pkg::text_t text,
    output logic                utf8_valid,
    input  wire logic           utf8_stall,
    output jsu_pkg::utf8_t      utf8
);

    logic           in_vld_reg;
    jsu_pkg::text_t in_data_reg;
    jsu_pkg::res_t  res;
    logic           buf_free;
    logic           adv;

    assign adv        = in_vld_reg && ((res.cnt == 3'd0) || buf_free);
    assign text_stall = in_vld_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (text_valid && !text_stall) begin
            in_vld_reg <= 1'b1;
        end else if (adv) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall) begin
            in_data_reg <= text;
        end
    end

    jsu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_data_reg),
        .fire  (adv),
        .res   (res)
    );

    jsu_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (adv && (res.cnt != 3'd0)),
        .res   (res),
        .free  (buf_free),
        .valid (utf8_valid),
        .stall (utf8_stall),
        .data  (utf8)
    );

endmodule

`default_nettype wire

>>> verif/tb_json_string_unescape_utf8.sv
// Self-checking testbench for json_string_unescape_utf8: directed and random JSON string text,
// with results compared beat by beat against a built-in unescaper. Depends on jsu_pkg and the
// json_string_unescape_utf8 RTL only.
module tb_json_string_unescape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam int StuckLimit = 2000;
    localparam int RandomItems = 280;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_STR,
        DEC_ESC,
        DEC_HEX,
        DEC_HIGH,
        DEC_HIGH_BS,
        DEC_LOW
    } dec_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] val;
    } dir_row_t;

    localparam int DirCount = 27;
    localparam dir_row_t DirRows [DirCount] = '{
        '{8'h41,     1'b0, 1'b1, jsu_pkg::KIND_NO_OPEN, 8'h00},
        '{8'h00,     1'b1, 1'b1, jsu_pkg::KIND_NO_OPEN, 8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h00,     1'b0, 1'b1, jsu_pkg::KIND_DATA,    8'h00},
        '{8'hFF,     1'b0, 1'b1, jsu_pkg::KIND_DATA,    8'hFF},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h44,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h62,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h46,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h66,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h78,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h64,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h38,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h30,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h30,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h7A,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h65,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h30,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h30,     1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{CH_QUOTE,  1'b0, 1'b1, jsu_pkg::KIND_CLOSED,  8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_DATA,    8'h00},
        '{8'h00,     1'b1, 1'b1, jsu_pkg::KIND_UNTERM,  8'h00}
    };

    localparam logic [7:0] EscChars [8] = '{
        8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74
    };

    logic            clk;
    logic            rst_n;
    logic            text_valid;
    logic            text_stall;
    jsu_pkg::text_t  text;
    logic            utf8_valid;
    logic            utf8_stall;
    jsu_pkg::utf8_t  utf8;

    dec_mode_t       dec_mode;
    logic [1:0]      digit_cnt;
    logic [15:0]     unit_acc;
    logic [15:0]     high_acc;
    jsu_pkg::utf8_t  beat_res[$];
    jsu_pkg::utf8_t  decoded_q[$];
    jsu_pkg::text_t  text_q[$];

    bit calm;
    bit hold_req;
    int err_cnt = 0;
    int stuck_cycles = 0;

    json_string_unescape_utf8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .utf8_valid (utf8_valid),
        .utf8_stall (utf8_stall),
        .utf8       (utf8)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void reset_decoder();
        dec_mode  = DEC_IDLE;
        digit_cnt = 2'd0;
        unit_acc  = 16'h0000;
        high_acc  = 16'h0000;
    endfunction

    function automatic void put_res(logic [7:0] b, logic [1:0] k);
        jsu_pkg::utf8_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = 1'b0;
        beat_res   = {beat_res, r};
    endfunction

    function automatic void put_code_point(logic [31:0] cp);
        if (cp < 32'h80)
        begin
            put_res(cp[7:0], jsu_pkg::KIND_DATA);
        end
        else if (cp < 32'h800)
        begin
            put_res(8'(32'hC0 | (cp >> 6)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | (cp & 32'h3F)), jsu_pkg::KIND_DATA);
        end
        else if (cp < 32'h10000)
        begin
            put_res(8'(32'hE0 | (cp >> 12)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | ((cp >> 6) & 32'h3F)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | (cp & 32'h3F)), jsu_pkg::KIND_DATA);
        end
        else
        begin
            put_res(8'(32'hF0 | (cp >> 18)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | ((cp >> 12) & 32'h3F)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | ((cp >> 6) & 32'h3F)), jsu_pkg::KIND_DATA);
            put_res(8'(32'h80 | (cp & 32'h3F)), jsu_pkg::KIND_DATA);
        end
    endfunction

    function automatic logic [3:0] hex_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 4'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return 4'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46)
            return 4'(c - 8'h41 + 8'd10);
        return 4'd0;
    endfunction

    function automatic void string_char(logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            put_res(8'h00, jsu_pkg::KIND_CLOSED);
            dec_mode = DEC_IDLE;
        end
        else if (c == CH_BSLASH)
        begin
            dec_mode = DEC_ESC;
        end
        else
        begin
            put_res(c, jsu_pkg::KIND_DATA);
        end
    endfunction

    function automatic void escape_char(logic [7:0] c);
        logic [7:0] b;
        b = c;
        if (c == CH_U)
        begin
            dec_mode  = DEC_HEX;
            digit_cnt = 2'd0;
            unit_acc  = 16'h0000;
            return;
        end
        case (c)
            8'h62: b = 8'h08;
            8'h66: b = 8'h0C;
            8'h6E: b = 8'h0A;
            8'h72: b = 8'h0D;
            8'h74: b = 8'h09;
            default: ;
        endcase
        put_res(b, jsu_pkg::KIND_DATA);
        dec_mode = DEC_STR;
    endfunction

    function automatic bit take_digit(logic [7:0] c);
        unit_acc = {unit_acc[11:0], hex_value(c)};
        if (digit_cnt == 2'd3)
        begin
            digit_cnt = 2'd0;
            return 1'b1;
        end
        digit_cnt = digit_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void unescape_beat(jsu_pkg::text_t t);
        logic [7:0]  c;
        logic [31:0] cp;
        beat_res.delete();
        c = t.char_byte;
        if (t.text_end)
        begin
            case (dec_mode)
                DEC_STR, DEC_ESC, DEC_HEX, DEC_LOW:
                    put_res(8'h00, jsu_pkg::KIND_UNTERM);
                DEC_HIGH, DEC_HIGH_BS:
                begin
                    put_code_point(32'(high_acc));
                    put_res(8'h00, jsu_pkg::KIND_UNTERM);
                end
                default:
                    put_res(8'h00, jsu_pkg::KIND_NO_OPEN);
            endcase
            reset_decoder();
        end
        else
        begin
            case (dec_mode)
                DEC_STR:
                    string_char(c);
                DEC_ESC:
                    escape_char(c);
                DEC_HEX:
                begin
                    if (take_digit(c))
                    begin
                        if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF)
                        begin
                            high_acc = unit_acc;
                            dec_mode = DEC_HIGH;
                        end
                        else
                        begin
                            put_code_point(32'(unit_acc));
                            dec_mode = DEC_STR;
                        end
                    end
                end
                DEC_HIGH:
                begin
                    if (c == CH_BSLASH)
                    begin
                        dec_mode = DEC_HIGH_BS;
                    end
                    else
                    begin
                        put_code_point(32'(high_acc));
                        dec_mode = DEC_STR;
                        string_char(c);
                    end
                end
                DEC_HIGH_BS:
                begin
                    if (c == CH_U)
                    begin
                        dec_mode  = DEC_LOW;
                        digit_cnt = 2'd0;
                        unit_acc  = 16'h0000;
                    end
                    else
                    begin
                        put_code_point(32'(high_acc));
                        escape_char(c);
                    end
                end
                DEC_LOW:
                begin
                    if (take_digit(c))
                    begin
                        cp = 32'h10000 + ((32'(high_acc) - 32'hD800) << 10)
                             + (32'(unit_acc) - 32'hDC00);
                        put_code_point(cp);
                        dec_mode = DEC_STR;
                    end
                end
                default:
                begin
                    dec_mode = DEC_IDLE;
                    if (c == CH_QUOTE)
                        dec_mode = DEC_STR;
                    else
                        put_res(8'h00, jsu_pkg::KIND_NO_OPEN);
                end
            endcase
        end
        if (beat_res.size() > 0)
            beat_res[beat_res.size() - 1].last = 1'b1;
    endfunction

    function automatic void push_char(logic [7:0] c);
        jsu_pkg::text_t t;
        t.char_byte = c;
        t.text_end  = 1'b0;
        text_q      = {text_q, t};
    endfunction

    function automatic void push_end();
        jsu_pkg::text_t t;
        t.char_byte = 8'($urandom_range(0, 255));
        t.text_end  = 1'b1;
        text_q      = {text_q, t};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit bad);
        if (bad)
            return ($urandom_range(0, 1) != 0) ? 8'h67 : 8'($urandom_range(0, 255));
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_unit(logic [15:0] u);
        push_char(CH_BSLASH);
        push_char(CH_U);
        for (int s = 3; s >= 0; s--)
            push_char(hex_char(u[s*4 +: 4], $urandom_range(0, 11) == 0));
    endfunction

    function automatic void push_random_text();
        int         n;
        int         pick;
        int         esc_idx;
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                    push_end();
                else
                    push_char(8'($urandom_range(0, 255)));
            end
            return;
        end
        push_char(CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = c ^ 8'h01;
                push_char(c);
            end
            else if (pick < 55)
            begin
                push_char(CH_BSLASH);
                esc_idx = $urandom_range(0, 8);
                push_char(esc_idx < 8 ? EscChars[esc_idx] : 8'($urandom_range(0, 255)));
            end
            else if (pick < 70)
            begin
                push_unit(16'($urandom_range(0, 65535)));
            end
            else if (pick < 85)
            begin
                push_unit(16'hD800 + 16'($urandom_range(0, 1023)));
                if ($urandom_range(0, 3) == 0)
                    push_unit(16'($urandom_range(0, 65535)));
                else
                    push_unit(16'hDC00 + 16'($urandom_range(0, 1023)));
            end
            else if (pick < 95)
            begin
                push_unit(16'hD800 + 16'($urandom_range(0, 1023)));
            end
            else
            begin
                push_char(CH_BSLASH);
                if ($urandom_range(0, 1) != 0)
                begin
                    push_char(CH_U);
                    repeat ($urandom_range(0, 3))
                        push_char(hex_char(4'($urandom_range(0, 15)), 1'b0));
                end
                push_end();
                return;
            end
        end
        if ($urandom_range(0, 6) == 0)
            push_end();
        else
            push_char(CH_QUOTE);
    endfunction

    task automatic send_text(input jsu_pkg::text_t t, input bit typed, input logic [1:0] kind,
                             input logic [7:0] val);
        jsu_pkg::utf8_t r;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text       <= t;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        unescape_beat(t);
        if (typed)
        begin
            r.out_byte = val;
            r.kind     = kind;
            r.last     = 1'b1;
            decoded_q  = {decoded_q, r};
        end
        else
        begin
            foreach (beat_res[i])
                decoded_q = {decoded_q, beat_res[i]};
        end
    endtask

    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        utf8_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                utf8_stall <= 1'b1;
            end
            else
            begin
                utf8_stall <= !calm && ($urandom_range(0, 99) < 17);
            end
        end
    end

    always @(posedge clk)
    begin
        jsu_pkg::utf8_t want;
        if (rst_n && utf8_valid && !utf8_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("utf8 beat with nothing expected: out_byte %02h kind %0d last %0d",
                       utf8.out_byte, utf8.kind, utf8.last);
                err_cnt++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (utf8.out_byte !== want.out_byte)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.out_byte, utf8.out_byte);
                    err_cnt++;
                end
                if (utf8.kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, utf8.kind);
                    err_cnt++;
                end
                if (utf8.last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, utf8.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && !text_stall) || (utf8_valid && !utf8_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= StuckLimit)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        jsu_pkg::text_t t;
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text       = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        reset_decoder();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DirRows[i])
        begin
            t.char_byte = DirRows[i].ch;
            t.text_end  = DirRows[i].fin;
            send_text(t, DirRows[i].typed, DirRows[i].kind, DirRows[i].val);
        end

        while (text_q.size() < RandomItems)
            push_random_text();

        foreach (text_q[i])
        begin
            calm = (i >= 60 && i < 120);
            if (i == 200)
                hold_req = 1'b1;
            if (i == 150)
            begin
                @(negedge clk);
                text_valid <= 1'b0;
                while (decoded_q.size() != 0)
                    @(negedge clk);
            end
            send_text(text_q[i], 1'b0, jsu_pkg::KIND_DATA, 8'h00);
        end
        @(negedge clk);
        text_valid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
